/* rtl/nsts_pkg.sv */
package nsts_pkg;

   // song memory geometry
   localparam int SONG_DEPTH = 256;
   localparam int IDX_W      = $clog2(SONG_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SONG_DEPTH - 1);

   // millisecond counters
   localparam int MS_W = 18;
   localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

   // register reset values
   localparam logic [23:0] BEAT_RESET = 24'd128000;
   localparam logic [7:0]  VOL_RESET  = 8'd255;
   localparam logic [31:0] PITCH_C0   = 32'd4186;
   localparam logic [31:0] PITCH_SAT  = 32'hFFFF_FFFF;

   // note codes inside a note word
   localparam logic [3:0] CODE_REST = 4'd12;
   localparam logic [3:0] CODE_BUZZ = 4'd13;
   localparam logic [3:0] CODE_END  = 4'd14;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_START = 2'd2,
      FUNC_STOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_BEAT = 2'd0,
      CSR_GAP  = 2'd1,
      CSR_LOOP = 2'd2,
      CSR_VOL  = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      KIND_TONE = 2'd0,
      KIND_REST = 2'd1,
      KIND_BUZZ = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [31:0]      pitch_q8;
      logic [MS_W-1:0]  sound_ms;
      logic [MS_W-1:0]  note_ms;
      logic [7:0]       level;
   } rsp_type;

   // octave zero frequencies, hz in q8, c up to b
   function automatic logic [12:0] semitone_q8(input logic [3:0] semi);
      logic [12:0] val;
      case (semi)
         4'd0:    val = 13'd4186;
         4'd1:    val = 13'd4434;
         4'd2:    val = 13'd4698;
         4'd3:    val = 13'd4978;
         4'd4:    val = 13'd5274;
         4'd5:    val = 13'd5587;
         4'd6:    val = 13'd5919;
         4'd7:    val = 13'd6271;
         4'd8:    val = 13'd6644;
         4'd9:    val = 13'd7039;
         4'd10:   val = 13'd7458;
         4'd11:   val = 13'd7901;
         default: val = 13'd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/nsts_ram.sv */
module nsts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the write address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nsts_out_buf.sv */
module nsts_out_buf
   import nsts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = in_valid;
            skid_data_in  = in_data;
         end else begin
            out_valid_in  = in_valid;
            out_data_in   = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (in_valid && out_valid_ff && !out_ready && !skid_valid_ff) |=> skid_valid_ff)
      else $error("result dropped while output stalled");

   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> (out_valid_ff && out_data_ff == $past(out_data_ff)))
      else $error("output changed while stalled");

endmodule

/* rtl/note_sequencer_tone_scheduler.sv */
// note sequencer and tone scheduler. one request transaction is taken per clock
// cycle, back to back: load a note word, start, stop, or a one millisecond tick.
// every request is decoded in the cycle it is accepted, and a tick that ends the
// current note yields one response transaction, which passes through the output
// register; a two-entry output buffer keeps requests flowing while a response
// waits, so req_tready only drops when both entries are full. the note memory
// (256 words, one write and one registered read port) is read every cycle at
// the play index the sequencer will hold next, so the word for the current note
// is always on hand; a load to the address being read is forwarded. the memory
// has no clearing pass: a note word must be loaded before play reaches it.
// configuration is taken at any time (csr_ready is always high), but should
// only be written while the block is idle.
module note_sequencer_tone_scheduler
   import nsts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // load_index[7:0], load_word[39:8]
   input  logic [1:0]  req_tuser,   // func[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // pitch_q8[31:0], sound_ms[49:32], note_ms[67:50],
                                    // level[75:68], zero[79:76]
   output logic [1:0]  rsp_tuser,   // sound_kind[1:0]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   // configuration registers
   logic [23:0]     beat_ff;
   logic [MS_W-1:0] gap_ff;
   logic            loop_ff;
   logic [7:0]      vol_ff;

   // sequencer state
   logic [IDX_W-1:0] play_ff, play_in;
   logic [MS_W-1:0]  elapsed_ff, elapsed_in;
   logic [MS_W-1:0]  wait_ff, wait_in;
   logic             running_ff, running_in;
   kind_type         kind_ff, kind_in;
   logic [31:0]      pitch_ff, pitch_in;

   // copy of note word zero, used when the end marker wraps play around
   logic [31:0] word0_ff, word0_in;

   // read forwarding for a load that hits the address being read
   logic             fwd_valid_ff, fwd_valid_in;
   logic [31:0]      fwd_data_ff;

   logic             req_accept;
   func_type         func;
   logic [IDX_W-1:0] load_addr;
   logic [31:0]      load_word;
   logic             ram_we;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      ram_rdata;
   logic [31:0]      cur_word;

   logic             cur_end;
   logic [31:0]      sel_word;
   logic [IDX_W-1:0] sel_idx, next_idx;
   logic [3:0]       sel_code;
   logic [5:0]       sel_oct;
   logic [15:0]      sel_len;

   logic [MS_W-1:0]  el_inc;
   logic             fire;

   logic [39:0]      prod;
   logic [17:0]      q_hi;
   logic [18:0]      c_sum;
   logic [16:0]      e_sum;
   logic             e_carry;
   logic [18:0]      dur_full;
   logic [MS_W-1:0]  dur;
   logic [MS_W-1:0]  snd;

   logic [12:0]      base;
   logic [44:0]      shifted;
   logic [31:0]      tone;

   logic             push;
   rsp_type          push_data;
   rsp_type          rsp_data;

   assign req_accept = req_tvalid && req_tready;
   assign func       = func_type'(req_tuser);
   assign load_addr  = req_tdata[IDX_W-1:0];
   assign load_word  = req_tdata[39:8];

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff <= BEAT_RESET;
         gap_ff  <= '0;
         loop_ff <= 1'b0;
         vol_ff  <= VOL_RESET;
      end else if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_BEAT: beat_ff <= csr_data;
            CSR_GAP:  gap_ff  <= csr_data[MS_W-1:0];
            CSR_LOOP: loop_ff <= csr_data[0];
            CSR_VOL:  vol_ff  <= csr_data[7:0];
            default:  ;
         endcase
      end
   end

   // ---------------------------------------------------------------- memory
   nsts_ram #(
      .WIDTH (32),
      .DEPTH (SONG_DEPTH)
   ) u_note_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (load_addr),
      .wr_data (load_word),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // read the word for the play index of the next cycle
   assign rd_addr      = reset ? '0 : play_in;
   assign fwd_valid_in = ram_we && (load_addr == rd_addr);
   assign cur_word     = fwd_valid_ff ? fwd_data_ff : ram_rdata;

   // ---------------------------------------------------------------- note decode
   assign cur_end  = (cur_word[29:26] == CODE_END);
   assign sel_word = cur_end ? word0_ff : cur_word;
   assign sel_idx  = cur_end ? '0 : play_ff;
   assign next_idx = (sel_idx == IDX_LAST) ? '0 : sel_idx + IDX_W'(1);
   assign sel_code = sel_word[29:26];
   assign sel_oct  = sel_word[21:16];
   assign sel_len  = sel_word[15:0];

   assign el_inc = (elapsed_ff != MS_MAX) ? elapsed_ff + MS_W'(1) : elapsed_ff;
   assign fire   = (el_inc > wait_ff) || (el_inc == MS_MAX);

   // duration = floor(beat * len * 4 / (65535 * 256))
   // drop the 2^6 first, then divide by 2^16 - 1 via the fold q = a*65535 + (a + b)
   assign prod     = {16'd0, beat_ff} * {24'd0, sel_len};
   assign q_hi     = prod[39:22];
   assign c_sum    = {1'b0, q_hi} + {3'b000, prod[21:6]};
   assign e_sum    = {14'd0, c_sum[18:16]} + {1'b0, c_sum[15:0]};
   assign e_carry  = (e_sum >= 17'd65535);
   assign dur_full = {1'b0, q_hi} + {16'd0, c_sum[18:16]} + {18'd0, e_carry};
   assign dur      = dur_full[18] ? MS_MAX : dur_full[MS_W-1:0];
   assign snd      = (dur > gap_ff) ? dur - gap_ff : '0;

   // tone pitch, saturating once the shifted value leaves 32 bits
   assign base    = semitone_q8(sel_code);
   assign shifted = {32'd0, base} << sel_oct[4:0];
   assign tone    = (sel_oct[5] || (|shifted[44:32])) ? PITCH_SAT : shifted[31:0];

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      play_in    = play_ff;
      elapsed_in = elapsed_ff;
      wait_in    = wait_ff;
      running_in = running_ff;
      kind_in    = kind_ff;
      pitch_in   = pitch_ff;
      word0_in   = word0_ff;
      ram_we     = 1'b0;
      push       = 1'b0;
      if (req_accept) begin
         case (func)
            FUNC_LOAD: begin
               ram_we = 1'b1;
               if (load_addr == '0) begin
                  word0_in = load_word;
               end
            end
            FUNC_START: begin
               running_in = 1'b1;
               play_in    = '0;
               elapsed_in = '0;
               wait_in    = {2'b00, beat_ff[23:8]};
            end
            FUNC_STOP: begin
               running_in = 1'b0;
            end
            FUNC_TICK: begin
               if (running_ff) begin
                  elapsed_in = el_inc;
                  if (fire) begin
                     if (cur_end && !loop_ff) begin
                        // end of song without looping
                        running_in = 1'b0;
                     end else begin
                        push       = 1'b1;
                        elapsed_in = '0;
                        wait_in    = dur;
                        play_in    = next_idx;
                        if (sel_code inside {[4'd0:4'd11]}) begin
                           kind_in  = KIND_TONE;
                           pitch_in = tone;
                        end else if (sel_code == CODE_REST) begin
                           kind_in = KIND_REST;
                        end else if (sel_code == CODE_BUZZ) begin
                           kind_in = KIND_BUZZ;
                        end
                        // other codes keep the previous kind and pitch
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_ff      <= '0;
         elapsed_ff   <= '0;
         wait_ff      <= '0;
         running_ff   <= 1'b0;
         kind_ff      <= KIND_TONE;
         pitch_ff     <= PITCH_C0;
         fwd_valid_ff <= 1'b0;
      end else begin
         play_ff      <= play_in;
         elapsed_ff   <= elapsed_in;
         wait_ff      <= wait_in;
         running_ff   <= running_in;
         kind_ff      <= kind_in;
         pitch_ff     <= pitch_in;
         fwd_valid_ff <= fwd_valid_in;
      end
      word0_ff    <= word0_in;
      fwd_data_ff <= load_word;
   end

   // ---------------------------------------------------------------- response
   assign push_data.kind     = kind_in;
   assign push_data.pitch_q8 = pitch_in;
   assign push_data.sound_ms = snd;
   assign push_data.note_ms  = dur;
   assign push_data.level    = vol_ff;

   nsts_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_data   (push_data),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tuser = rsp_data.kind;
   assign rsp_tdata = {4'd0, rsp_data.level, rsp_data.note_ms,
                       rsp_data.sound_ms, rsp_data.pitch_q8};

   // ---------------------------------------------------------------- checks
   a_push_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      push |-> (req_accept && func == FUNC_TICK && running_ff))
      else $error("response produced by a non-tick request");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && func == FUNC_START) |=> (running_ff && elapsed_ff == '0 && play_ff == '0))
      else $error("start did not reset the sequencer");

   a_note_restarts_timer: assert property (@(posedge clock) disable iff (reset)
      push |=> (elapsed_ff == '0 && wait_ff == $past(dur)))
      else $error("note timer not restarted after a note");

endmodule

/* tb/tone_schedule_checker.sv */
module tone_schedule_checker
   import nsts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // load_index[7:0], load_word[39:8]
   input  logic [1:0]  req_tuser,   // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata,   // pitch_q8[31:0], sound_ms[49:32], note_ms[67:50],
                                    // level[75:68], zero[79:76]
   input  logic [1:0]  rsp_tuser,   // sound_kind[1:0]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        check_end,
   output int          pending,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] LEN_SCALE = 64'd16776960;   // 65535 * 256

   logic [31:0] octave0_q8 [0:11] = '{
      32'd4186, 32'd4434, 32'd4698, 32'd4978, 32'd5274, 32'd5587,
      32'd5919, 32'd6271, 32'd6644, 32'd7039, 32'd7458, 32'd7901
   };

   // shadow of the sequencer
   logic [31:0]     song [0:SONG_DEPTH-1];
   logic [IDX_W-1:0] cursor;
   logic [MS_W-1:0] elapsed;
   logic [MS_W-1:0] wait_len;
   logic            playing;
   kind_type        cur_kind;
   logic [31:0]     cur_pitch;

   logic [23:0]     beat_q8;
   logic [MS_W-1:0] gap;
   logic            looping;
   logic [7:0]      volume;

   rsp_type expected_notes [$];

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic advance_sequencer(func_type func, logic [7:0] index, logic [31:0] word);
      logic [31:0]     w;
      logic [3:0]      code;
      logic [5:0]      octave;
      logic [63:0]     prod;
      logic [63:0]     dur_full;
      logic [MS_W-1:0] dur;
      logic [31:0]     base;
      rsp_type         note;
      case (func)
         FUNC_LOAD: begin
            song[index] = word;
            return;
         end
         FUNC_START: begin
            playing  = 1'b1;
            cursor   = '0;
            elapsed  = '0;
            wait_len = MS_W'(beat_q8 >> 8);
            return;
         end
         FUNC_STOP: begin
            playing = 1'b0;
            return;
         end
         default: ;
      endcase
      if (!playing)
         return;
      if (elapsed != MS_MAX)
         elapsed++;
      if (!(elapsed > wait_len || elapsed == MS_MAX))
         return;

      w    = song[cursor];
      code = w[29:26];
      if (code == CODE_END) begin
         if (!looping) begin
            playing = 1'b0;
            return;
         end
         // wrap to the top; a second end marker there falls through as other
         cursor = '0;
         w      = song[0];
         code   = w[29:26];
      end
      octave = w[21:16];

      prod     = 64'(beat_q8) * 64'(w[15:0]) * 64'd4;
      dur_full = prod / LEN_SCALE;
      dur      = (dur_full > 64'(MS_MAX)) ? MS_MAX : dur_full[MS_W-1:0];

      if (code < 4'd12) begin
         cur_kind = KIND_TONE;
         base     = octave0_q8[code];
         if (octave >= 6'd32 || base > (PITCH_SAT >> octave))
            cur_pitch = PITCH_SAT;
         else
            cur_pitch = base << octave;
      end else if (code == CODE_REST) begin
         cur_kind = KIND_REST;
      end else if (code == CODE_BUZZ) begin
         cur_kind = KIND_BUZZ;
      end

      wait_len = dur;
      elapsed  = '0;
      cursor   = cursor + IDX_W'(1);

      note.kind     = cur_kind;
      note.pitch_q8 = cur_pitch;
      note.sound_ms = (dur > gap) ? dur - gap : '0;
      note.note_ms  = dur;
      note.level    = volume;
      expected_notes.push_back(note);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cursor     = '0;
         elapsed    = '0;
         wait_len   = '0;
         playing    = 1'b0;
         cur_kind   = KIND_TONE;
         cur_pitch  = PITCH_C0;
         beat_q8    = BEAT_RESET;
         gap        = '0;
         looping    = 1'b0;
         volume     = VOL_RESET;
         fail_count = 0;
         expected_notes.delete();
      end else begin
         // older expectations come first, so compare before predicting
         if (rsp_tvalid && rsp_tready) begin
            if (expected_notes.size() == 0) begin
               $error("response transaction with no expected note");
               fail_count++;
            end else begin
               rsp_type want;
               want = expected_notes.pop_front();
               check_field("sound_kind", want.kind, rsp_tuser);
               check_field("pitch_q8", want.pitch_q8, rsp_tdata[31:0]);
               check_field("sound_ms", want.sound_ms, rsp_tdata[49:32]);
               check_field("note_ms", want.note_ms, rsp_tdata[67:50]);
               check_field("level", want.level, rsp_tdata[75:68]);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_type'(csr_index))
               CSR_BEAT: beat_q8 = csr_data;
               CSR_GAP:  gap     = csr_data[MS_W-1:0];
               CSR_LOOP: looping = csr_data[0];
               CSR_VOL:  volume  = csr_data[7:0];
               default:  ;
            endcase
         end
         if (req_tvalid && req_tready)
            advance_sequencer(func_type'(req_tuser), req_tdata[7:0], req_tdata[39:8]);
         if (check_end && expected_notes.size() != 0) begin
            $error("%0d expected notes never arrived", expected_notes.size());
            fail_count++;
         end
      end
      pending = expected_notes.size();
   end

endmodule

/* tb/tb_note_sequencer_tone_scheduler.sv */
module tb_note_sequencer_tone_scheduler;
   import nsts_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 50_000;
   localparam int SETTLE_CYCLES = 8;      // output register plus skid entry, with margin
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off for the pressure phase
   localparam int RAND_ITEMS    = 44;     // random transactions per phase

   // semitones and the one note code the package leaves unnamed
   localparam logic [3:0] NOTE_C     = 4'd0;
   localparam logic [3:0] NOTE_E     = 4'd4;
   localparam logic [3:0] NOTE_B     = 4'd11;
   localparam logic [3:0] CODE_OTHER = 4'd15;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [23:0] csr_data;
   logic        check_end;
   int          pending;
   int          fail_count;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int stall_token    = 0;

   note_sequencer_tone_scheduler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   tone_schedule_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .check_end  (check_end),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit, counted in cycles
   initial begin : watchdog
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off whenever the token moves
   initial begin : receiver
      int hold_left;
      int seen;
      hold_left = 0;
      seen      = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_token != seen) begin
            seen      = stall_token;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 54; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 54; end
         default:   begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
   endtask

   // one request transaction; tvalid stays high unless a gap is drawn
   task automatic send_req(func_type func, logic [7:0] index, logic [31:0] word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {word, index};
      do @(posedge clock); while (!req_tready);
   endtask

   // tick, start or stop, with junk in the unused load fields
   task automatic send_op(func_type func);
      send_req(func, 8'($urandom), $urandom);
   endtask

   task automatic send_ticks(int count);
      repeat (count) send_op(FUNC_TICK);
   endtask

   // note word with random filler in the unused bits
   function automatic logic [31:0] make_word(logic [3:0] code, logic [5:0] octave,
                                             logic [15:0] len);
      logic [31:0] w;
      w        = $urandom;
      w[29:26] = code;
      w[21:16] = octave;
      w[15:0]  = len;
      return w;
   endfunction

   // mostly tones with short lengths so notes turn over quickly
   function automatic logic [31:0] random_word(bit allow_end);
      logic [3:0]  code;
      logic [5:0]  octave;
      logic [15:0] len;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 70)      code = 4'($urandom_range(0, 11));
      else if (pick < 80) code = CODE_REST;
      else if (pick < 88) code = CODE_BUZZ;
      else if (pick < 94) code = allow_end ? CODE_END : CODE_OTHER;
      else                code = CODE_OTHER;
      octave = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 12)) : 6'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 7)      len = 16'($urandom_range(0, 63));
      else if (pick < 9) len = 16'($urandom_range(0, 1023));
      else               len = 16'($urandom);
      return make_word(code, octave, len);
   endfunction

   // every address gets written so play never reads an unloaded word
   task automatic fill_song(bit allow_end);
      for (int i = 0; i < SONG_DEPTH; i++)
         send_req(FUNC_LOAD, 8'(i), random_word(allow_end));
   endtask

   // wait until the block has nothing left in flight
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_type index, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // registers only change once the block has nothing left in flight
   task automatic configure(logic [23:0] beat, logic [17:0] gap, logic loop_on,
                            logic [7:0] vol);
      drain();
      write_csr(CSR_BEAT, beat);
      write_csr(CSR_GAP, 24'(gap));
      write_csr(CSR_LOOP, 24'(loop_on));
      write_csr(CSR_VOL, 24'(vol));
      csr_valid <= 1'b0;
   endtask

   // play-heavy mix: mostly ticks, some loads, restarts and stops
   task automatic random_items(int count);
      int pick;
      send_op(FUNC_START);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 76)
            send_op(FUNC_TICK);
         else if (pick < 88)
            send_req(FUNC_LOAD,
                     $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom),
                     random_word(1'b1));
         else if (pick < 95)
            send_op(FUNC_START);
         else
            send_op(FUNC_STOP);
      end
   endtask

   initial begin : stimulus
      // every input known from time zero
      reset      = 1'b1;
      check_end  <= 1'b0;
      req_tvalid <= 1'b0;
      req_tuser  <= FUNC_TICK;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_BEAT;
      csr_data   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: one beat per 256 q8 means a one millisecond first wait
      set_idling(IDLE_NONE);
      configure(24'd256, 18'd1, 1'b0, 8'd200);
      fill_song(1'b1);

      send_req(FUNC_LOAD, 8'd0, make_word(NOTE_C, 6'd0, 16'd0));        // lowest tone
      send_req(FUNC_LOAD, 8'd1, make_word(NOTE_B, 6'd63, 16'hFFFF));    // saturated pitch
      send_req(FUNC_LOAD, 8'd2, make_word(CODE_REST, 6'd0, 16'd32768)); // rest inside gap
      send_req(FUNC_LOAD, 8'd3, make_word(CODE_OTHER, 6'd5, 16'd0));    // kind repeats
      send_req(FUNC_LOAD, 8'd4, make_word(CODE_BUZZ, 6'd0, 16'd0));
      send_req(FUNC_LOAD, 8'd5, make_word(NOTE_E, 6'd19, 16'd0));       // top unsaturated shift
      send_req(FUNC_LOAD, 8'd6, make_word(CODE_END, 6'd0, 16'd0));      // stop, looping off
      send_op(FUNC_TICK);                                                // ignored while stopped
      send_op(FUNC_STOP);
      send_op(FUNC_START);
      send_ticks(15);

      // end marker at address zero with looping on: it reads as other
      configure(24'd1024, 18'd0, 1'b1, 8'd255);
      send_req(FUNC_LOAD, 8'd0, make_word(CODE_END, 6'($urandom), 16'($urandom_range(0, 40))));
      send_op(FUNC_START);
      send_ticks(6);
      random_items(RAND_ITEMS);

      // zero beat makes every tick read a note; widest gap silences all
      set_idling(IDLE_SEND);
      configure(24'd0, MS_MAX, 1'b0, 8'd0);
      random_items(RAND_ITEMS);

      set_idling(IDLE_RECV);
      configure(24'd3000, 18'd2, 1'b1, 8'($urandom));
      random_items(RAND_ITEMS);

      set_idling(IDLE_BOTH);
      configure(24'd4095, 18'($urandom_range(0, 3)), 1'b0, 8'($urandom));
      random_items(RAND_ITEMS);

      // pressure: looping on with a zero beat gives one note per tick, and the
      // receiver is held off long enough to fill the output buffer
      set_idling(IDLE_NONE);
      configure(24'd0, 18'd0, 1'b1, 8'd77);
      stall_token++;
      send_op(FUNC_START);
      send_ticks(40);

      set_idling(IDLE_SEND);
      configure(24'($urandom_range(0, 4096)), 18'($urandom_range(0, 5)), 1'b1, 8'($urandom));
      random_items(RAND_ITEMS);

      set_idling(IDLE_BOTH);
      configure(24'($urandom_range(0, 4096)), 18'($urandom_range(0, 8)),
                1'($urandom), 8'($urandom));
      random_items(RAND_ITEMS);

      set_idling(IDLE_RECV);
      configure(24'($urandom_range(0, 4096)), 18'($urandom_range(0, 8)),
                1'($urandom), 8'($urandom));
      random_items(RAND_ITEMS);

      // widest beat: a one millisecond first wait, then the beat grows so the
      // note read next has the longest duration
      set_idling(IDLE_NONE);
      configure(24'd256, 18'($urandom), 1'b0, 8'd255);
      send_req(FUNC_LOAD, 8'd0, make_word(4'($urandom_range(0, 11)), 6'd3, 16'hFFFF));
      send_op(FUNC_START);
      send_op(FUNC_TICK);
      configure(24'hFF_FFFF, 18'($urandom), 1'b0, 8'd255);
      send_op(FUNC_TICK);
      send_op(FUNC_STOP);

      // wind down and check that nothing is left over
      drain();
      check_end <= 1'b1;
      @(posedge clock);
      check_end <= 1'b0;
      repeat (2) @(posedge clock);

      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
